FILE: hw/rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// Serial break controller package
// Shared codes, field widths and structs of the serial break controller.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int DELAY_FIELD_W = 24;
   localparam int PADDR_W       = 3;

   // Item kinds.
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // Break states.
   localparam logic [1:0] BRK_INACTIVE = 2'd0;
   localparam logic [1:0] BRK_TIMED    = 2'd1;
   localparam logic [1:0] BRK_LOCKED   = 2'd2;
   localparam logic [1:0] BRK_UNUSED   = 2'd3;

   // Parties.
   localparam logic [1:0] WHO_NONE   = 2'd0;
   localparam logic [1:0] WHO_DEVICE = 2'd2;

   // Request status codes.
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_IN_USE = 1'b1;

   // Register byte addresses.
   localparam logic [PADDR_W-1:0] CSR_CLIENT_ATTACHED = 3'd0;

   typedef struct packed {
      logic [1:0] state;
      logic [1:0] owner;
      logic       line;
   } sbc_ctl_type;

   typedef struct packed {
      logic       status;
      logic       transition_done;
      logic       break_active;
      logic [1:0] break_state;
      logic       host_notify;
      logic       client_change;
      logic       device_complete;
   } sbc_rsp_type;

endpackage

FILE: hw/rtl/sbc_if.sv
// ----------------------------------------------------------------------------
// Serial break controller channels
// Valid/ready channels for break requests and ticks, and for their results.
// ----------------------------------------------------------------------------
interface sbc_req_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [1:0]                       requester;
   logic [1:0]                       target_state;
   logic [sbc_pkg::DELAY_FIELD_W-1:0] delay_ticks;

   modport source (output valid, kind, requester, target_state, delay_ticks, input ready);
   modport sink   (input valid, kind, requester, target_state, delay_ticks, output ready);
endinterface

interface sbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic       transition_done;
   logic       break_active;
   logic [1:0] break_state;
   logic       host_notify;
   logic       client_change;
   logic       device_complete;

   modport source (output valid, status, transition_done, break_active, break_state,
                   host_notify, client_change, device_complete, input ready);
   modport sink   (input valid, status, transition_done, break_active, break_state,
                   host_notify, client_change, device_complete, output ready);
endinterface

FILE: hw/rtl/sbc_step.sv
// ----------------------------------------------------------------------------
// Serial break controller step logic
// Computes the next break state, owner, countdown and the result of one beat.
// ----------------------------------------------------------------------------
module sbc_step #(
   parameter int DELAY_BITS = 24
) (
   input  logic                             kind,
   input  logic [1:0]                       requester,
   input  logic [1:0]                       target_state,
   input  logic [sbc_pkg::DELAY_FIELD_W-1:0] delay_ticks,
   input  logic                             client_attached,
   input  sbc_pkg::sbc_ctl_type             ctl_cur,
   input  logic [DELAY_BITS-1:0]            ticks_cur,
   output sbc_pkg::sbc_ctl_type             ctl_next,
   output logic [DELAY_BITS-1:0]            ticks_next,
   output sbc_pkg::sbc_rsp_type             rsp
);

   localparam int WIDE_W =
      (DELAY_BITS > sbc_pkg::DELAY_FIELD_W) ? DELAY_BITS : sbc_pkg::DELAY_FIELD_W;

   logic [WIDE_W-1:0]     delay_wide;
   logic [WIDE_W-1:0]     max_wide;
   logic [DELAY_BITS-1:0] ticks_load;
   logic                  do_apply;
   logic [1:0]            a_who;
   logic [1:0]            a_target;
   logic                  a_zero_delay;
   logic                  legal;
   logic                  apply_ok;
   logic                  crossing;

   assign delay_wide = WIDE_W'(delay_ticks);
   assign max_wide   = WIDE_W'({DELAY_BITS{1'b1}});
   assign ticks_load = (delay_wide > max_wide) ? {DELAY_BITS{1'b1}}
                                               : DELAY_BITS'(delay_wide);

   always_comb begin
      ctl_next   = ctl_cur;
      ticks_next = ticks_cur;
      rsp        = '0;
      rsp.status = sbc_pkg::STATUS_OK;
      do_apply   = 1'b0;
      a_who      = requester;
      a_target   = target_state;
      a_zero_delay = (delay_ticks == '0);
      legal      = 1'b0;
      apply_ok   = 1'b0;
      crossing   = 1'b0;

      if (kind == sbc_pkg::KIND_REQUEST) begin
         if (requester != ctl_cur.owner && ctl_cur.owner != sbc_pkg::WHO_NONE) begin
            rsp.status = sbc_pkg::STATUS_IN_USE;
         end else begin
            do_apply = 1'b1;
         end
      end else if (ctl_cur.state == sbc_pkg::BRK_TIMED) begin
         if (ticks_cur > DELAY_BITS'(1)) begin
            ticks_next = ticks_cur - DELAY_BITS'(1);
         end else begin
            // Countdown expired: the owner's break ends as a request for inactive.
            do_apply     = 1'b1;
            a_who        = ctl_cur.owner;
            a_target     = sbc_pkg::BRK_INACTIVE;
            a_zero_delay = 1'b1;
            ticks_next   = '0;
         end
      end

      unique case (a_target)
         sbc_pkg::BRK_INACTIVE: legal = (ctl_cur.state != sbc_pkg::BRK_INACTIVE) &&
                                        (ctl_cur.state != sbc_pkg::BRK_UNUSED);
         sbc_pkg::BRK_TIMED:    legal = (ctl_cur.state != sbc_pkg::BRK_UNUSED);
         sbc_pkg::BRK_LOCKED:   legal = (ctl_cur.state == sbc_pkg::BRK_INACTIVE) ||
                                        (ctl_cur.state == sbc_pkg::BRK_TIMED);
         default:               legal = 1'b0;
      endcase

      apply_ok = legal && !(a_target == sbc_pkg::BRK_TIMED && a_zero_delay);
      crossing = (ctl_cur.state != a_target) &&
                 (ctl_cur.state == sbc_pkg::BRK_INACTIVE ||
                  a_target == sbc_pkg::BRK_INACTIVE);

      if (do_apply) begin
         // A failed change still records the requester, except for inactive.
         ctl_next.owner = (a_target == sbc_pkg::BRK_INACTIVE) ? sbc_pkg::WHO_NONE : a_who;
         if (apply_ok) begin
            ctl_next.state      = a_target;
            ctl_next.line       = (a_target != sbc_pkg::BRK_INACTIVE);
            ticks_next          = (a_target == sbc_pkg::BRK_TIMED) ? ticks_load : '0;
            rsp.transition_done = 1'b1;
            rsp.host_notify     = crossing;
            rsp.client_change   = crossing && client_attached;
            rsp.device_complete = crossing && client_attached &&
                                  a_target == sbc_pkg::BRK_INACTIVE &&
                                  a_who == sbc_pkg::WHO_DEVICE;
         end
      end

      rsp.break_active = ctl_next.line;
      rsp.break_state  = ctl_next.state;
   end

endmodule

FILE: hw/rtl/serial_break_controller_unit.sv
// ----------------------------------------------------------------------------
// Serial break controller unit
// Owns the serial BREAK condition and answers requests and ticks one by one.
// ----------------------------------------------------------------------------
// Each beat on the request channel (a break request or a timer tick) yields
// exactly one result beat. The unit takes one beat per clock cycle while the
// result side is ready; a beat lands in an input register, and when it moves
// on, the step logic updates the break state, owner and countdown and writes
// the result register. The state update loop sets the rate. The
// client_attached register sits at byte address 0 of the APB port and should
// be written only while no beat is in flight.
module serial_break_controller_unit #(
   parameter int DELAY_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   sbc_req_if.sink                            req_chan,
   sbc_rsp_if.source                          rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sbc_pkg::PADDR_W-1:0]        paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic                              client_ff;
   logic                              in_vld_ff;
   logic                              in_vld_in;
   logic                              in_kind_ff;
   logic [1:0]                        in_requester_ff;
   logic [1:0]                        in_target_ff;
   logic [sbc_pkg::DELAY_FIELD_W-1:0] in_delay_ff;
   logic                              rsp_vld_ff;
   logic                              rsp_vld_in;
   sbc_pkg::sbc_rsp_type              rsp_ff;
   sbc_pkg::sbc_rsp_type              rsp_in;
   sbc_pkg::sbc_ctl_type              ctl_ff;
   sbc_pkg::sbc_ctl_type              ctl_in;
   logic [DELAY_BITS-1:0]             ticks_ff;
   logic [DELAY_BITS-1:0]             ticks_in;
   logic                              req_take;
   logic                              advance;
   logic                              csr_write;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      paddr == sbc_pkg::CSR_CLIENT_ATTACHED;

   always_comb begin
      prdata = '0;
      if (paddr == sbc_pkg::CSR_CLIENT_ATTACHED) begin
         prdata = {31'd0, client_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         client_ff <= 1'b0;
      end else if (csr_write) begin
         client_ff <= pwdata[0];
      end
   end

   // Two-stage flow: the input register moves on whenever the result register
   // is empty or being drained, so a new beat can enter every cycle.
   assign advance        = in_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign in_vld_in      = req_take || (in_vld_ff && !advance);
   assign rsp_vld_in     = advance || (rsp_vld_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         ctl_ff     <= '0;
         ticks_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            ctl_ff   <= ctl_in;
            ticks_ff <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff      <= req_chan.kind;
         in_requester_ff <= req_chan.requester;
         in_target_ff    <= req_chan.target_state;
         in_delay_ff     <= req_chan.delay_ticks;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   sbc_step #(
      .DELAY_BITS (DELAY_BITS)
   ) u_step (
      .kind            (in_kind_ff),
      .requester       (in_requester_ff),
      .target_state    (in_target_ff),
      .delay_ticks     (in_delay_ff),
      .client_attached (client_ff),
      .ctl_cur         (ctl_ff),
      .ticks_cur       (ticks_ff),
      .ctl_next        (ctl_in),
      .ticks_next      (ticks_in),
      .rsp             (rsp_in)
   );

   assign rsp_chan.valid           = rsp_vld_ff;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.transition_done = rsp_ff.transition_done;
   assign rsp_chan.break_active    = rsp_ff.break_active;
   assign rsp_chan.break_state     = rsp_ff.break_state;
   assign rsp_chan.host_notify     = rsp_ff.host_notify;
   assign rsp_chan.client_change   = rsp_ff.client_change;
   assign rsp_chan.device_complete = rsp_ff.device_complete;

`ifndef ASSERT_OFF
   // The break line is high exactly while a timed or locked break is held.
   a_line_matches_state: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.line == (ctl_ff.state != sbc_pkg::BRK_INACTIVE))
      else $error("break line level disagrees with break state");

   // The countdown only runs in the timed state.
   a_ticks_idle_zero: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.state != sbc_pkg::BRK_TIMED |-> ticks_ff == '0)
      else $error("countdown nonzero outside the timed state");

   // A completion pulse only comes with the end of a break seen by the host.
   a_complete_with_notify: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.device_complete |->
         rsp_ff.host_notify && rsp_ff.break_state == sbc_pkg::BRK_INACTIVE)
      else $error("device completion without an end of break");

   // A held input beat keeps its place until the result register takes it.
   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff)
      else $error("input beat dropped before it was processed");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial break controller unit testbench
// Drives break requests and timer ticks into the unit, predicts every result
// beat with a cycle-free model of the break owner, state and countdown, and
// compares each result field by field. The client_attached register is set
// over the APB port between phases and read back. Both channel sides idle at
// random, the result side also holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          HOLD_CYCLES  = 80;
   localparam int          SETTLE_TICKS = 8;
   localparam int          MAX_REPORTS  = 40;
   localparam int unsigned TICK_BITS    = 24;
   localparam longint      TICK_MAX     = (64'd1 << TICK_BITS) - 1;
   localparam logic [1:0]  WHO_HOST     = 2'd1;
   localparam logic [1:0]  WHO_OTHER    = 2'd3;

   typedef struct packed {
      logic                              kind;
      logic [1:0]                        requester;
      logic [1:0]                        target_state;
      logic [sbc_pkg::DELAY_FIELD_W-1:0] delay_ticks;
   } brk_item_type;

   logic                        clock;
   logic                        reset;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [sbc_pkg::PADDR_W-1:0] paddr;
   logic [31:0]                 pwdata;
   logic [31:0]                 prdata;
   logic                        pready;

   sbc_req_if req_if ();
   sbc_rsp_if rsp_if ();

   serial_break_controller_unit #(
      .DELAY_BITS(TICK_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Predicted break controller state.
   logic                 brk_client;
   logic [1:0]           brk_state;
   logic [1:0]           brk_owner;
   logic [TICK_BITS-1:0] brk_ticks;
   logic                 brk_line;

   sbc_pkg::sbc_rsp_type break_results_due[$];

   int  error_count   = 0;
   int  result_count  = 0;
   int  cycle_count   = 0;
   int  request_count = 0;
   int  tick_count    = 0;
   int  refused_count = 0;
   int  expiry_count  = 0;
   int  finish_count  = 0;
   bit  idle_on       = 1'b1;
   bit  hold_output   = 1'b0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run timed out after %0d cycles", CYCLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: result beat %0d: %s", $realtime, result_count, msg);
   endtask

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic bit change_is_legal(input logic [1:0] from, input logic [1:0] to);
      case (from)
         sbc_pkg::BRK_INACTIVE: return to == sbc_pkg::BRK_TIMED || to == sbc_pkg::BRK_LOCKED;
         sbc_pkg::BRK_TIMED:    return to != sbc_pkg::BRK_UNUSED;
         sbc_pkg::BRK_LOCKED:   return to == sbc_pkg::BRK_INACTIVE || to == sbc_pkg::BRK_TIMED;
         default:               return 1'b0;
      endcase
   endfunction

   // Applies a request from a party that is allowed to act. The requester
   // takes ownership even when the change fails; any request for inactive
   // leaves the break unowned.
   function automatic logic apply_break_change(input logic [1:0] who,
                                               input logic [1:0] target,
                                               input logic [sbc_pkg::DELAY_FIELD_W-1:0] delay,
                                               inout sbc_pkg::sbc_rsp_type rsp);
      logic applied;
      applied   = 1'b0;
      brk_owner = who;
      if (change_is_legal(brk_state, target) &&
          !(target == sbc_pkg::BRK_TIMED && delay == 0)) begin
         if (target == sbc_pkg::BRK_TIMED) begin
            brk_ticks = (longint'(delay) > TICK_MAX) ? TICK_MAX[TICK_BITS-1:0]
                                                     : TICK_BITS'(delay);
            brk_line  = 1'b1;
         end else begin
            brk_ticks = '0;
            brk_line  = (target == sbc_pkg::BRK_LOCKED);
         end
         if (brk_state != target && (brk_state == sbc_pkg::BRK_INACTIVE ||
                                     target == sbc_pkg::BRK_INACTIVE)) begin
            rsp.host_notify   = 1'b1;
            rsp.client_change = brk_client;
            if (target == sbc_pkg::BRK_INACTIVE && brk_owner == sbc_pkg::WHO_DEVICE) begin
               rsp.device_complete = brk_client;
               if (brk_client)
                  finish_count++;
            end
         end
         brk_state = target;
         applied   = 1'b1;
      end
      if (target == sbc_pkg::BRK_INACTIVE)
         brk_owner = sbc_pkg::WHO_NONE;
      return applied;
   endfunction

   function automatic sbc_pkg::sbc_rsp_type predict_break_result(input brk_item_type it);
      sbc_pkg::sbc_rsp_type rsp;
      rsp = '0;
      if (it.kind == sbc_pkg::KIND_REQUEST) begin
         request_count++;
         if (it.requester != brk_owner && brk_owner != sbc_pkg::WHO_NONE) begin
            rsp.status = sbc_pkg::STATUS_IN_USE;
            refused_count++;
         end else begin
            rsp.transition_done = apply_break_change(it.requester, it.target_state,
                                                     it.delay_ticks, rsp);
         end
      end else begin
         tick_count++;
         if (brk_state == sbc_pkg::BRK_TIMED) begin
            if (brk_ticks > 1) begin
               brk_ticks--;
            end else begin
               brk_ticks = '0;
               expiry_count++;
               rsp.transition_done = apply_break_change(brk_owner, sbc_pkg::BRK_INACTIVE,
                                                        '0, rsp);
            end
         end
      end
      rsp.break_active = brk_line;
      rsp.break_state  = brk_state;
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: stalls and checking
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         if (hold_output) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      sbc_pkg::sbc_rsp_type got;
      sbc_pkg::sbc_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         result_count++;
         got = {rsp_if.status, rsp_if.transition_done, rsp_if.break_active,
                rsp_if.break_state, rsp_if.host_notify, rsp_if.client_change,
                rsp_if.device_complete};
         if (break_results_due.size() == 0) begin
            report_mismatch("result beat arrived with nothing outstanding");
         end else begin
            want = break_results_due.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0b, expected %0b", got.status, want.status));
            if (got.transition_done !== want.transition_done)
               report_mismatch($sformatf("transition_done %0b, expected %0b",
                                         got.transition_done, want.transition_done));
            if (got.break_active !== want.break_active)
               report_mismatch($sformatf("break_active %0b, expected %0b",
                                         got.break_active, want.break_active));
            if (got.break_state !== want.break_state)
               report_mismatch($sformatf("break_state %0d, expected %0d",
                                         got.break_state, want.break_state));
            if (got.host_notify !== want.host_notify)
               report_mismatch($sformatf("host_notify %0b, expected %0b",
                                         got.host_notify, want.host_notify));
            if (got.client_change !== want.client_change)
               report_mismatch($sformatf("client_change %0b, expected %0b",
                                         got.client_change, want.client_change));
            if (got.device_complete !== want.device_complete)
               report_mismatch($sformatf("device_complete %0b, expected %0b",
                                         got.device_complete, want.device_complete));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side and register port
   // ------------------------------------------------------------------------
   function automatic brk_item_type make_item(input logic kind, input logic [1:0] who,
                                              input logic [1:0] target,
                                              input logic [sbc_pkg::DELAY_FIELD_W-1:0] delay);
      brk_item_type it;
      it.kind         = kind;
      it.requester    = who;
      it.target_state = target;
      it.delay_ticks  = delay;
      return it;
   endfunction

   // Most requests come from the current owner so that sequences get past the
   // in-use refusal; short delays let the countdown run out on ticks.
   function automatic brk_item_type random_item();
      brk_item_type it;
      int           pick;
      it.kind = ($urandom_range(0, 99) < 35) ? sbc_pkg::KIND_TICK : sbc_pkg::KIND_REQUEST;
      pick = $urandom_range(0, 99);
      if (brk_owner != sbc_pkg::WHO_NONE && pick < 65)
         it.requester = brk_owner;
      else if (pick < 90)
         it.requester = 2'($urandom_range(1, 2));
      else
         it.requester = 2'($urandom_range(0, 3));
      it.target_state = ($urandom_range(0, 99) < 92) ? 2'($urandom_range(0, 2))
                                                     : sbc_pkg::BRK_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         it.delay_ticks = sbc_pkg::DELAY_FIELD_W'($urandom_range(1, 6));
      else if (pick < 70)
         it.delay_ticks = '0;
      else if (pick < 80)
         it.delay_ticks = '1;
      else
         it.delay_ticks = sbc_pkg::DELAY_FIELD_W'($urandom);
      return it;
   endfunction

   // Called right after a rising edge; returns at the edge the beat is taken.
   task automatic send_item(input brk_item_type it);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.kind         <= it.kind;
      req_if.requester    <= it.requester;
      req_if.target_state <= it.target_state;
      req_if.delay_ticks  <= it.delay_ticks;
      do @(posedge clock); while (!req_if.ready);
      break_results_due.push_back(predict_break_result(it));
   endtask

   // Stops offering beats and waits until every outstanding result is in.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (break_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [sbc_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_client_attached(input logic value);
      logic [31:0] rdata;
      drain_results();
      csr_access(1'b1, sbc_pkg::CSR_CLIENT_ATTACHED, {31'b0, value}, rdata);
      brk_client = value;
      csr_access(1'b0, sbc_pkg::CSR_CLIENT_ATTACHED, '0, rdata);
      if (rdata[0] !== value)
         report_mismatch($sformatf("client_attached read back %0b, expected %0b",
                                   rdata[0], value));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_cases();
      brk_item_type detached[$];
      brk_item_type attached[$];
      detached = '{
         // tick while idle
         make_item(sbc_pkg::KIND_TICK,    WHO_HOST,           sbc_pkg::BRK_TIMED,    24'd0),
         // zero delay fails
         make_item(sbc_pkg::KIND_REQUEST, WHO_HOST,           sbc_pkg::BRK_TIMED,    24'd0),
         // refused, in use
         make_item(sbc_pkg::KIND_REQUEST, sbc_pkg::WHO_DEVICE, sbc_pkg::BRK_LOCKED,  24'd0),
         make_item(sbc_pkg::KIND_REQUEST, WHO_HOST,           sbc_pkg::BRK_TIMED,    24'd2),
         make_item(sbc_pkg::KIND_TICK,    sbc_pkg::WHO_NONE,  sbc_pkg::BRK_INACTIVE, 24'd0),
         // countdown goes on
         make_item(sbc_pkg::KIND_REQUEST, WHO_HOST,           sbc_pkg::BRK_TIMED,    24'd0),
         // expires
         make_item(sbc_pkg::KIND_TICK,    WHO_OTHER,          sbc_pkg::BRK_UNUSED,   24'hFFFFFF),
         // illegal target
         make_item(sbc_pkg::KIND_REQUEST, sbc_pkg::WHO_NONE,  sbc_pkg::BRK_UNUSED,   24'h5A5A5A),
         make_item(sbc_pkg::KIND_REQUEST, WHO_OTHER,          sbc_pkg::BRK_LOCKED,   24'd0),
         // refused
         make_item(sbc_pkg::KIND_REQUEST, WHO_HOST,           sbc_pkg::BRK_INACTIVE, 24'd0),
         make_item(sbc_pkg::KIND_REQUEST, WHO_OTHER,          sbc_pkg::BRK_TIMED,    24'hFFFFFF),
         make_item(sbc_pkg::KIND_REQUEST, WHO_OTHER,          sbc_pkg::BRK_INACTIVE, 24'd0)
      };
      attached = '{
         make_item(sbc_pkg::KIND_REQUEST, sbc_pkg::WHO_DEVICE, sbc_pkg::BRK_TIMED,    24'd1),
         // refused
         make_item(sbc_pkg::KIND_REQUEST, WHO_HOST,            sbc_pkg::BRK_LOCKED,   24'd0),
         // device break ends
         make_item(sbc_pkg::KIND_TICK,    WHO_HOST,            sbc_pkg::BRK_INACTIVE, 24'd0),
         make_item(sbc_pkg::KIND_REQUEST, sbc_pkg::WHO_DEVICE, sbc_pkg::BRK_LOCKED,   24'd0),
         // locked to locked
         make_item(sbc_pkg::KIND_REQUEST, sbc_pkg::WHO_DEVICE, sbc_pkg::BRK_LOCKED,   24'd0),
         make_item(sbc_pkg::KIND_REQUEST, sbc_pkg::WHO_DEVICE, sbc_pkg::BRK_INACTIVE, 24'd0),
         // already inactive
         make_item(sbc_pkg::KIND_REQUEST, sbc_pkg::WHO_DEVICE, sbc_pkg::BRK_INACTIVE, 24'd0),
         make_item(sbc_pkg::KIND_REQUEST, WHO_HOST,            sbc_pkg::BRK_LOCKED,   24'd0),
         make_item(sbc_pkg::KIND_REQUEST, WHO_HOST,            sbc_pkg::BRK_TIMED,    24'd5),
         make_item(sbc_pkg::KIND_REQUEST, WHO_HOST,            sbc_pkg::BRK_INACTIVE, 24'd0)
      };
      set_client_attached(1'b0);
      foreach (detached[i]) send_item(detached[i]);
      set_client_attached(1'b1);
      foreach (attached[i]) send_item(attached[i]);
   endtask

   task automatic test_random_phases();
      logic settings[4] = '{1'b1, 1'b0, 1'b1, 1'b0};
      foreach (settings[p]) begin
         set_client_attached(settings[p]);
         repeat (130) send_item(random_item());
      end
   endtask

   // The result side holds off while beats keep coming, so the unit fills up
   // and has to stall its request side.
   task automatic test_output_stall();
      set_client_attached(1'b1);
      hold_output = 1'b1;
      repeat (30) send_item(random_item());
      drain_results();
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (220) send_item(random_item());
   endtask

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.kind         <= sbc_pkg::KIND_REQUEST;
      req_if.requester    <= sbc_pkg::WHO_NONE;
      req_if.target_state <= sbc_pkg::BRK_INACTIVE;
      req_if.delay_ticks  <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      brk_client = 1'b0;
      brk_state  = sbc_pkg::BRK_INACTIVE;
      brk_owner  = sbc_pkg::WHO_NONE;
      brk_ticks  = '0;
      brk_line   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_phases();
      test_output_stall();
      test_back_to_back();
      drain_results();

      $display("Covered %0d requests and %0d ticks over %0d result beats.",
               request_count, tick_count, result_count);
      $display("Saw %0d in-use refusals, %0d timer expiries, %0d device completions.",
               refused_count, expiry_count, finish_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
